/* rtl/hnft_pkg.sv */
// Shared types and constants of the HDLC NRZI frame transmitter.
`default_nettype none

package hnft_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FILLER_MODE     = 1'b0,
    CFG_INVERT_POLARITY = 1'b1
  } cfg_reg_e;

  // Command kinds handed from the front end to the bit engine
  typedef enum logic [1:0] {
    CMD_FLAG     = 2'd0,
    CMD_PREAMBLE = 2'd1,
    CMD_DATA     = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       open_flag;
    logic [7:0] data;
    logic       last;
    logic       corrupt;
  } cmd_t;

  localparam logic [7:0]  FlagByte     = 8'h7E;
  // 0x55 sent MSB first equals 0xAA sent LSB first
  localparam logic [7:0]  PreambleLsb  = 8'hAA;
  localparam logic [15:0] CrcPoly      = 16'h8408;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [2:0]  StuffLimit   = 3'd5;

endpackage

`default_nettype wire

/* rtl/hnft_if.sv */
// Channel interfaces of the HDLC NRZI frame transmitter.
`default_nettype none

interface hnft_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       corrupt_fcs;

  modport source (output valid, action, data_byte, last_byte, corrupt_fcs, input ready);
  modport sink   (input valid, action, data_byte, last_byte, corrupt_fcs, output ready);
endinterface

interface hnft_bit_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic end_of_run;

  modport source (output valid, line_bit, end_of_run, input ready);
  modport sink   (input valid, line_bit, end_of_run, output ready);
endinterface

interface hnft_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/hdlc_nrzi_frame_transmitter.sv */
// Top level of the HDLC NRZI frame transmitter with CRC-16/X.25 FCS.
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+------------
//  item_i  | in  | action, data_byte[7:0], last_byte, corrupt_fcs | valid/ready
//  line_o  | out | line_bit, end_of_run                         | valid/ready
//  cfg_i   | in  | index[0:0], data                             | valid/ready
//
//  The bit engine sends one line bit per cycle while the line takes it: a filler
//  request sends one byte, a data byte its bits plus any stuffed zeros, an opening
//  flag goes before the first byte of a frame, and the FCS and closing flag follow
//  the last byte. The next request is taken as soon as the current one ends.
//  Reset clears frame state, the FCS register and the queue; no clearing pass.
//  A two-request queue lets the front end keep accepting while the line stalls;
//  a stalled line holds the output register and freezes the engine.
`default_nettype none

module hdlc_nrzi_frame_transmitter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hnft_item_if.sink  item_i,
  hnft_bit_if.source line_o,
  hnft_cfg_if.sink   cfg_i
);
  import hnft_pkg::*;

  logic filler_mode_q;
  logic invert_polarity_q;

  logic push;
  logic full;
  logic pop;
  logic cmd_valid;
  cmd_t front_cmd;
  cmd_t queue_cmd;

  // configuration is always taken at once
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filler_mode_q     <= 1'b0;
      invert_polarity_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FILLER_MODE:     filler_mode_q     <= cfg_i.data;
        CFG_INVERT_POLARITY: invert_polarity_q <= cfg_i.data;
      endcase
    end
  end

  // classify requests and track whether a frame is open
  hnft_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .filler_mode_i (filler_mode_q),
    .item_i        (item_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // decouple request acceptance from line timing
  hnft_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (queue_cmd)
  );

  // serialise: flags, stuffed bytes, FCS, preamble
  hnft_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .invert_polarity_i (invert_polarity_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (queue_cmd),
    .pop_o             (pop),
    .line_o            (line_o)
  );

endmodule

`default_nettype wire

/* rtl/hnft_front.sv */
// Front end: accepts byte requests, tracks frame state and builds commands.
`default_nettype none

module hnft_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          filler_mode_i,
  hnft_item_if.sink          item_i,
  input  wire logic          full_i,
  output      logic          push_o,
  output      hnft_pkg::cmd_t cmd_o
);
  import hnft_pkg::*;

  logic in_frame_q, in_frame_d;

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  always_comb begin
    cmd_o.open_flag = 1'b0;
    cmd_o.data      = item_i.data_byte;
    cmd_o.last      = item_i.last_byte;
    cmd_o.corrupt   = item_i.corrupt_fcs;
    in_frame_d      = in_frame_q;
    if (item_i.action) begin
      cmd_o.kind      = CMD_DATA;
      cmd_o.open_flag = !in_frame_q;
      if (push_o) begin
        in_frame_d = !item_i.last_byte;
      end
    end else begin
      // filler abandons any open frame
      cmd_o.kind = filler_mode_i ? CMD_PREAMBLE : CMD_FLAG;
      if (push_o) begin
        in_frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/hnft_cmd_fifo.sv */
// Two-entry command queue between front end and bit engine.
`default_nettype none

module hnft_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hnft_pkg::cmd_t cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           valid_o,
  output      hnft_pkg::cmd_t cmd_o
);
  import hnft_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/hnft_back.sv */
// Bit engine: serialises commands with stuffing, NRZI and FCS generation.
`default_nettype none

module hnft_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           invert_polarity_i,
  input  wire logic           cmd_valid_i,
  input  wire hnft_pkg::cmd_t cmd_i,
  output      logic           pop_o,
  hnft_bit_if.source          line_o
);
  import hnft_pkg::*;

  typedef enum logic [2:0] {
    SEG_FILL_FLAG,
    SEG_PRE,
    SEG_FLAG_OPEN,
    SEG_DATA,
    SEG_FCS_LO,
    SEG_FCS_HI,
    SEG_FLAG_CLOSE
  } seg_e;

  seg_e        seg_q, seg_d;
  logic        busy_q, busy_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic        stuff_q, stuff_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic        corrupt_q, corrupt_d;
  logic        nrzi_q, nrzi_d;
  logic [2:0]  ones_q, ones_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic        out_bit_q, out_bit_d;
  logic        out_end_q, out_end_d;

  logic        emit_en;
  logic        cur;
  logic        lvl;
  logic [15:0] crc_step;
  logic [15:0] crc_fin;
  logic [15:0] fcs_new;
  logic [15:0] fcs_old;

  assign emit_en = busy_q && (!out_valid_q || line_o.ready);
  assign cur     = shift_q[0];
  assign lvl     = cur ? nrzi_q : !nrzi_q;
  assign crc_step = {1'b0, crc_q[15:1]} ^ ((crc_q[0] ^ cur) ? CrcPoly : 16'h0000);
  // a data byte that ends on a stuffed zero has already folded its last bit
  assign crc_fin  = stuff_q ? crc_q : crc_step;
  assign fcs_new  = corrupt_q ? crc_fin : ~crc_fin;
  assign fcs_old  = corrupt_q ? crc_q : ~crc_q;

  assign line_o.valid      = out_valid_q;
  assign line_o.line_bit   = out_bit_q;
  assign line_o.end_of_run = out_end_q;

  always_comb begin
    logic seg_done;
    logic run_done;
    seg_done    = 1'b0;
    run_done    = 1'b0;
    seg_d       = seg_q;
    busy_d      = busy_q;
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    stuff_d     = stuff_q;
    data_d      = data_q;
    last_d      = last_q;
    corrupt_d   = corrupt_q;
    nrzi_d      = nrzi_q;
    ones_d      = ones_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    out_end_d   = out_end_q;
    pop_o       = 1'b0;

    if (out_valid_q && line_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (emit_en) begin
      out_valid_d = 1'b1;
      if (stuff_q) begin
        // stuffed zero: always a transition
        nrzi_d    = !nrzi_q;
        out_bit_d = !nrzi_q;
        stuff_d   = 1'b0;
        ones_d    = 3'd0;
        seg_done  = (bit_cnt_q == 3'd0);
      end else begin
        shift_d   = {1'b0, shift_q[7:1]};
        bit_cnt_d = bit_cnt_q + 3'd1;
        unique case (seg_q)
          SEG_PRE: begin
            out_bit_d = cur ^ invert_polarity_i;
            seg_done  = (bit_cnt_q == 3'd7);
          end
          SEG_FILL_FLAG, SEG_FLAG_OPEN, SEG_FLAG_CLOSE: begin
            nrzi_d    = lvl;
            out_bit_d = lvl;
            seg_done  = (bit_cnt_q == 3'd7);
          end
          SEG_DATA, SEG_FCS_LO, SEG_FCS_HI: begin
            nrzi_d    = lvl;
            out_bit_d = lvl;
            if (seg_q == SEG_DATA) begin
              crc_d = crc_step;
            end
            if (cur) begin
              if ((ones_q + 3'd1) == StuffLimit) begin
                stuff_d = 1'b1;
                ones_d  = 3'd0;
              end else begin
                ones_d = ones_q + 3'd1;
              end
            end else begin
              ones_d = 3'd0;
            end
            seg_done = (bit_cnt_q == 3'd7) && !stuff_d;
          end
          default: begin
            seg_done = 1'b0;
          end
        endcase
      end

      if (seg_done) begin
        bit_cnt_d = 3'd0;
        unique case (seg_q)
          SEG_FLAG_OPEN: begin
            ones_d  = 3'd0;
            crc_d   = CrcInit;
            seg_d   = SEG_DATA;
            shift_d = data_q;
          end
          SEG_DATA: begin
            if (last_q) begin
              seg_d   = SEG_FCS_LO;
              shift_d = fcs_new[7:0];
            end else begin
              run_done = 1'b1;
            end
          end
          SEG_FCS_LO: begin
            seg_d   = SEG_FCS_HI;
            shift_d = fcs_old[15:8];
          end
          SEG_FCS_HI: begin
            seg_d   = SEG_FLAG_CLOSE;
            shift_d = FlagByte;
          end
          SEG_FLAG_CLOSE, SEG_FILL_FLAG: begin
            ones_d   = 3'd0;
            crc_d    = CrcInit;
            run_done = 1'b1;
          end
          SEG_PRE: begin
            crc_d    = CrcInit;
            run_done = 1'b1;
          end
          default: begin
            run_done = 1'b1;
          end
        endcase
      end
      out_end_d = run_done;
      if (run_done) begin
        busy_d = 1'b0;
      end
    end

    // take the next command as soon as the current one ends
    if ((!busy_q || run_done) && cmd_valid_i) begin
      pop_o     = 1'b1;
      busy_d    = 1'b1;
      bit_cnt_d = 3'd0;
      data_d    = cmd_i.data;
      last_d    = cmd_i.last;
      corrupt_d = cmd_i.corrupt;
      unique case (cmd_i.kind)
        CMD_PREAMBLE: begin
          seg_d   = SEG_PRE;
          shift_d = PreambleLsb;
        end
        CMD_FLAG: begin
          seg_d   = SEG_FILL_FLAG;
          shift_d = FlagByte;
        end
        default: begin
          if (cmd_i.open_flag) begin
            seg_d   = SEG_FLAG_OPEN;
            shift_d = FlagByte;
          end else begin
            seg_d   = SEG_DATA;
            shift_d = cmd_i.data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_FILL_FLAG;
      busy_q      <= 1'b0;
      bit_cnt_q   <= 3'd0;
      stuff_q     <= 1'b0;
      nrzi_q      <= 1'b0;
      ones_q      <= 3'd0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      busy_q      <= busy_d;
      bit_cnt_q   <= bit_cnt_d;
      stuff_q     <= stuff_d;
      nrzi_q      <= nrzi_d;
      ones_q      <= ones_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      out_end_q   <= out_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    data_q    <= data_d;
    last_q    <= last_d;
    corrupt_q <= corrupt_d;
    out_bit_q <= out_bit_d;
  end

  // the run counter clears before it can reach the stuffing limit
  a_ones_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q < StuffLimit)
    else $error("ones run reached stuffing limit");

  // a pending stuffed zero belongs to a stuffed segment of a live command
  a_stuff_in_stuffed_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuff_q |-> (busy_q && (seg_q == SEG_DATA || seg_q == SEG_FCS_LO || seg_q == SEG_FCS_HI)))
    else $error("stuffed zero pending outside a stuffed segment");

  // a pending stuffed zero goes out at the next emitted bit
  a_stuff_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stuff_q && emit_en) |=> !stuff_q)
    else $error("stuffed zero not sent");

  // a stalled result holds its bit and its end marker
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !line_o.ready) |=> (out_valid_q && $stable(out_bit_q) && $stable(out_end_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
